/* hdl/rraqs_pkg.sv */
package rraqs_pkg;

  // Item kinds carried in the kind field of an input word.
  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  // Widths fixed by the channel definition.
  localparam int QIDX_BITS = 3;
  localparam int WORD_BITS = 32;

  typedef struct packed {
    logic                 kind;
    logic [QIDX_BITS-1:0] queue_index;
    logic [WORD_BITS-1:0] demand_word;
  } in_word_t;

  typedef struct packed {
    logic                 push_refused;
    logic                 served_valid;
    logic [QIDX_BITS-1:0] served_queue;
    logic [WORD_BITS-1:0] served_demand;
    logic                 others_pending;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FINISH
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_blocked;
  } dp_status_t;

endpackage

/* hdl/round_robin_active_queue_scheduler.sv */
// Round-robin scheduler over a set of FIFO subqueues of demand words.
// Input channel (in_valid, in_stall, in_word): each word is either a push,
// which appends demand_word to subqueue queue_index, or a serve, which takes
// the oldest demand from the subqueue at the head of the active list.
// Result channel (out_valid, out_stall, out_word): exactly one result word is
// produced for every input word, in order.
// The word is captured in the item register when accepted, executed
// (bookkeeping plus demand-store access) in the EXEC state and loaded into
// the result register in the FINISH state. A new word is accepted only
// after the previous result has been loaded; the pace is set by the
// controller's three-state sequence around the demand store and its
// registered read.
// A stall on the result side holds the pending result in the output
// register; one further word may be accepted and executed meanwhile, and
// it then waits in the result stage until the output register frees.
// Reset (rst_n low, synchronous) empties every subqueue and the active list
// at once; the demand store and active list contents need no clearing.
module round_robin_active_queue_scheduler #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int DEMAND_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rraqs_pkg::in_word_t  in_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rraqs_pkg::out_word_t out_word
);

  // Controller and datapath talk only through these two bundles.
  rraqs_pkg::dp_cmd_t    cmd;
  rraqs_pkg::dp_status_t status;
  rraqs_pkg::state_t     state;

  rraqs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd),
    .state    (state)
  );

  rraqs_dpath #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DEMAND_BITS (DEMAND_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // A result is never loaded over one that is still being held.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid && out_stall))
    else $error("result loaded over a stalled word");

  // Once a word is taken, the input side is busy in the following cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (in_stall && state == rraqs_pkg::ST_EXEC))
    else $error("input accepted without entering execute");

  // A result word never reports both a served demand and a refused push.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_word.served_valid && out_word.push_refused))
    else $error("result word flags both serve and refusal");

  // A fresh result appears only straight after the load step.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state == rraqs_pkg::ST_FINISH))
    else $error("result raised outside the load step");

endmodule

/* hdl/rraqs_ctrl.sv */
module rraqs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rraqs_pkg::dp_status_t status,
  output rraqs_pkg::dp_cmd_t   cmd,
  output rraqs_pkg::state_t    state
);

  rraqs_pkg::state_t state_r;
  rraqs_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rraqs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.capture  = 1'b0;
    cmd.execute  = 1'b0;
    cmd.load_out = 1'b0;
    in_stall     = 1'b1;
    case (state_r)
      rraqs_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = rraqs_pkg::ST_EXEC;
        end
      end
      rraqs_pkg::ST_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = rraqs_pkg::ST_FINISH;
      end
      rraqs_pkg::ST_FINISH: begin
        // Wait here until the output register can take the result.
        if (!status.out_blocked) begin
          cmd.load_out = 1'b1;
          state_nxt    = rraqs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rraqs_pkg::ST_IDLE;
      end
    endcase
  end

  assign state = state_r;

endmodule

/* hdl/rraqs_dpath.sv */
module rraqs_dpath #(
  parameter int NUM_QUEUES  = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int DEMAND_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rraqs_pkg::dp_cmd_t    cmd,
  output rraqs_pkg::dp_status_t status,
  input  rraqs_pkg::in_word_t   in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rraqs_pkg::out_word_t  out_word
);

  localparam int QW = $clog2(NUM_QUEUES);
  localparam int CW = $clog2(NUM_QUEUES + 1);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int AW = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int MEM_WORDS = NUM_QUEUES * QUEUE_DEPTH;

  // Captured item.
  rraqs_pkg::in_word_t item_r;

  // Active list.
  logic [QW-1:0] ring_r [NUM_QUEUES];
  logic [QW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Per-subqueue bookkeeping.
  logic [FW-1:0] fill_r [NUM_QUEUES];
  logic [PW-1:0] rptr_r [NUM_QUEUES];

  // Demand store.
  logic [DEMAND_BITS-1:0] mem_r [MEM_WORDS];
  logic [DEMAND_BITS-1:0] rd_data_r;

  // Result of the execute step, waiting for the output register.
  logic                          res_refused_r;
  logic                          res_valid_r;
  logic [rraqs_pkg::QIDX_BITS-1:0] res_queue_r;
  logic                          res_pending_r;

  rraqs_pkg::out_word_t out_word_r, out_word_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic          is_push;
  logic          push_q_ok;
  logic [QW-1:0] sel_q;
  logic [FW-1:0] cur_fill;
  logic [PW-1:0] cur_rp;
  logic          push_ok;
  logic          serve_any;
  logic          serve_ok;
  logic [PW:0]   pos_sum;
  logic [PW-1:0] wr_pos;
  logic [PW-1:0] rp_inc;
  logic [QW:0]   tail_sum;
  logic [QW-1:0] tail;
  logic [QW-1:0] head_inc;
  logic          append_push;
  logic          append_serve;
  logic [AW-1:0] base_addr;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  always_comb begin
    is_push   = (item_r.kind == rraqs_pkg::KIND_PUSH);
    push_q_ok = (32'(item_r.queue_index) < NUM_QUEUES);
    sel_q     = is_push ? QW'(item_r.queue_index) : ring_r[head_r];
    cur_fill  = fill_r[sel_q];
    cur_rp    = rptr_r[sel_q];

    push_ok   = is_push && push_q_ok && (cur_fill != FW'(QUEUE_DEPTH));
    serve_any = !is_push && (count_r != '0);
    serve_ok  = serve_any && (cur_fill != '0);

    // Write slot: read pointer plus fill, wrapped once.
    pos_sum = (PW+1)'(cur_rp) + (PW+1)'(cur_fill);
    if (pos_sum >= (PW+1)'(QUEUE_DEPTH)) begin
      wr_pos = PW'(pos_sum - (PW+1)'(QUEUE_DEPTH));
    end else begin
      wr_pos = PW'(pos_sum);
    end
    rp_inc = (cur_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : cur_rp + PW'(1);

    // Tail slot of the active list, the same for push and for a re-linked serve.
    tail_sum = (QW+1)'(head_r) + (QW+1)'(count_r);
    if (tail_sum >= (QW+1)'(NUM_QUEUES)) begin
      tail = QW'(tail_sum - (QW+1)'(NUM_QUEUES));
    end else begin
      tail = QW'(tail_sum);
    end
    head_inc = (head_r == QW'(NUM_QUEUES - 1)) ? '0 : head_r + QW'(1);

    append_push  = push_ok && (cur_fill == '0) && (count_r < CW'(NUM_QUEUES));
    append_serve = serve_ok && (cur_fill > FW'(1));

    head_nxt  = head_r;
    count_nxt = count_r;
    if (push_ok) begin
      count_nxt = count_r + CW'(append_push);
    end else if (serve_any) begin
      head_nxt  = head_inc;
      count_nxt = count_r - CW'(1) + CW'(append_serve);
    end

    base_addr = AW'(sel_q * QUEUE_DEPTH);
    wr_addr   = base_addr + AW'(wr_pos);
    rd_addr   = base_addr + AW'(cur_rp);
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else if (cmd.execute) begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && (append_push || append_serve)) begin
      ring_r[tail] <= sel_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        fill_r[i] <= '0;
        rptr_r[i] <= '0;
      end
    end else if (cmd.execute) begin
      if (push_ok) begin
        fill_r[sel_q] <= cur_fill + FW'(1);
      end else if (serve_ok) begin
        fill_r[sel_q] <= cur_fill - FW'(1);
        rptr_r[sel_q] <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && push_ok) begin
      mem_r[wr_addr] <= DEMAND_BITS'(item_r.demand_word);
    end
    if (cmd.execute) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      res_refused_r <= is_push && !push_ok;
      res_valid_r   <= serve_ok;
      res_queue_r   <= serve_ok ? rraqs_pkg::QIDX_BITS'(sel_q) : '0;
      res_pending_r <= (count_nxt != '0);
    end
  end

  always_comb begin
    out_word_nxt = out_word_r;
    if (cmd.load_out) begin
      out_word_nxt.push_refused   = res_refused_r;
      out_word_nxt.served_valid   = res_valid_r;
      out_word_nxt.served_queue   = res_queue_r;
      out_word_nxt.served_demand  = res_valid_r ? rraqs_pkg::WORD_BITS'(rd_data_r) : '0;
      out_word_nxt.others_pending = res_pending_r;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign status.out_blocked = out_valid_r && out_stall;
  assign out_valid          = out_valid_r;
  assign out_word           = out_word_r;

endmodule
